// ===== hw/rtl/keyed_singly_linked_list_defines.svh =====
// assertion macros for the keyed singly linked list checker
`ifndef KEYED_SINGLY_LINKED_LIST_DEFINES_SVH
`define KEYED_SINGLY_LINKED_LIST_DEFINES_SVH

// same-cycle implication
`define KSLL_ASSERT_IMPLY(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("keyed list check failed");

// next-cycle implication
`define KSLL_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("keyed list check failed");

`endif

// ===== hw/rtl/ksll_pkg.sv =====
// types and constants shared by the keyed singly linked list
`default_nettype none
package ksll_pkg;
  localparam int unsigned PTR_W = 7;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned LEN_W = 7;

  typedef logic [PTR_W-1:0] ptr_t;
  localparam ptr_t NIL = 7'h7f;

  localparam logic [3:0] ACT_INS_HEAD   = 4'd0;
  localparam logic [3:0] ACT_INS_TAIL   = 4'd1;
  localparam logic [3:0] ACT_INS_BEFORE = 4'd2;
  localparam logic [3:0] ACT_INS_AFTER  = 4'd3;
  localparam logic [3:0] ACT_DEL_HEAD   = 4'd4;
  localparam logic [3:0] ACT_DEL_TAIL   = 4'd5;
  localparam logic [3:0] ACT_DEL_AFTER  = 4'd6;
  localparam logic [3:0] ACT_CLEAR      = 4'd7;
  localparam logic [3:0] ACT_DUMP       = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BAD       = 3'd4;

  typedef struct packed {
    logic [3:0]              action;
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] key;
  } item_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] item_value;
    logic [LEN_W-1:0]        length;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic             rd_en;
    ptr_t             rd_addr;
    logic             val_we;
    ptr_t             val_addr;
    logic [VAL_W-1:0] val_data;
    logic             lnk_we;
    ptr_t             lnk_addr;
    ptr_t             lnk_data;
  } mem_req_t;

  typedef struct packed {
    logic [VAL_W-1:0] val;
    ptr_t             link;
  } mem_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ksll_node_mem.sv =====
// node pool memories: values and next links, registered read
`default_nettype none
module ksll_node_mem #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic               clk_i,
  input  wire ksll_pkg::mem_req_t req_i,
  output ksll_pkg::mem_rsp_t      rsp_o
);
  import ksll_pkg::*;

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [VAL_W-1:0] val_mem [CAPACITY];
  ptr_t             lnk_mem [CAPACITY];

  always_ff @(posedge clk_i) begin
    if (req_i.val_we) begin
      val_mem[req_i.val_addr[IDX_W-1:0]] <= req_i.val_data;
    end
    if (req_i.lnk_we) begin
      lnk_mem[req_i.lnk_addr[IDX_W-1:0]] <= req_i.lnk_data;
    end
    if (req_i.rd_en) begin
      rsp_o.val  <= val_mem[req_i.rd_addr[IDX_W-1:0]];
      rsp_o.link <= lnk_mem[req_i.rd_addr[IDX_W-1:0]];
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/keyed_singly_linked_list.sv =====
// keyed singly linked list over a bounded node pool
// usage:
//   an item (action, value, key) is taken when start_i is high and busy_o low.
//   each result appears on res_o for one cycle with res_valid_o high; the
//   receiver takes it then and cannot hold it off.
//   every action gives one result with last set, except a dump of a non-empty
//   list, which gives one result per node in order and sets last on the tail.
// sequencing:
//   clear, bad actions, full inserts at the ends and deletes, keyed inserts
//   and dump on an empty list answer in the cycle after the item is taken.
//   a head insert steps through S_ALLOC, S_FREE when it reuses a freed node,
//   and S_PLACE; a tail insert to a non-empty list adds S_LINK2.
//   keyed actions, tail delete and dump walk the list through the node memory
//   at one node per cycle, set by the single read port of the node memory.
//   busy_o falls in the cycle that carries the final result; the next item
//   may be taken at the edge that takes that result.
// reset:
//   the list comes up empty with the whole pool unused; no clearing pass.
`default_nettype none
module keyed_singly_linked_list #(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire ksll_pkg::item_t item_i,
  output logic                 busy_o,
  output logic                 res_valid_o,
  output ksll_pkg::result_t    res_o
);
  import ksll_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;
  localparam logic [2:0] S_PLACE = 3'd4;
  localparam logic [2:0] S_LINK2 = 3'd5;
  localparam logic [2:0] S_DELRD = 3'd6;

  localparam logic [1:0] M_HEAD  = 2'd0;
  localparam logic [1:0] M_TAIL  = 2'd1;
  localparam logic [1:0] M_AFTER = 2'd2;

  localparam logic [LEN_W-1:0] CAP_L = LEN_W'(CAPACITY);

  function automatic logic live(ptr_t p);
    return p < PTR_W'(CAPACITY);
  endfunction

  logic [2:0]       state_q, state_d;
  logic [3:0]       act_q, act_d;
  logic [VAL_W-1:0] value_q, value_d, key_q, key_d;
  ptr_t             cur_q, cur_d, prev_q, prev_d, nx_q, nx_d, n_q, n_d;
  ptr_t             w2a_q, w2a_d, w2d_q, w2d_d;
  logic [1:0]       mode_q, mode_d;
  ptr_t             head_q, head_d, tail_q, tail_d, free_q, free_d;
  logic [LEN_W-1:0] nu_q, nu_d, cnt_q, cnt_d;
  logic             rv_q, rv_d;
  result_t          res_q, res_d;

  mem_req_t req;
  mem_rsp_t rsp;
  logic     fin;
  logic [2:0] fin_st;
  logic     full, hit;

  ksll_node_mem #(.CAPACITY(CAPACITY)) u_mem (
    .clk_i (clk_i),
    .req_i (req),
    .rsp_o (rsp)
  );

  assign full = cnt_q >= CAP_L;
  assign hit  = rsp.val == key_q;

  always_comb begin
    state_d = state_q;
    act_d   = act_q;
    value_d = value_q;
    key_d   = key_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    nx_d    = nx_q;
    n_d     = n_q;
    w2a_d   = w2a_q;
    w2d_d   = w2d_q;
    mode_d  = mode_q;
    head_d  = head_q;
    tail_d  = tail_q;
    free_d  = free_q;
    nu_d    = nu_q;
    cnt_d   = cnt_q;
    rv_d    = 1'b0;
    res_d   = res_q;
    req     = '0;
    fin     = 1'b0;
    fin_st  = ST_OK;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          act_d   = item_i.action;
          value_d = item_i.value;
          key_d   = item_i.key;
          case (item_i.action)
            ACT_INS_HEAD, ACT_INS_TAIL: begin
              if (full) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else begin
                mode_d  = (item_i.action == ACT_INS_HEAD) ? M_HEAD : M_TAIL;
                state_d = S_ALLOC;
              end
            end
            ACT_CLEAR: begin
              head_d = NIL;
              tail_d = NIL;
              free_d = NIL;
              nu_d   = '0;
              cnt_d  = '0;
              fin    = 1'b1;
            end
            ACT_INS_BEFORE, ACT_INS_AFTER, ACT_DEL_HEAD, ACT_DEL_TAIL,
            ACT_DEL_AFTER, ACT_DUMP: begin
              if (!live(head_q)) begin
                fin    = 1'b1;
                fin_st = ST_EMPTY;
              end else begin
                req.rd_en   = 1'b1;
                req.rd_addr = head_q;
                cur_d       = head_q;
                state_d     = S_WALK;
              end
            end
            default: begin
              fin    = 1'b1;
              fin_st = ST_BAD;
            end
          endcase
        end
      end

      S_WALK: begin
        case (act_q)
          ACT_INS_BEFORE, ACT_INS_AFTER: begin
            if (hit) begin
              if (act_q == ACT_INS_BEFORE && cur_q == head_q) begin
                mode_d = M_HEAD;
              end else begin
                mode_d = M_AFTER;
                if (act_q == ACT_INS_BEFORE) begin
                  nx_d = cur_q;
                end else begin
                  prev_d = cur_q;
                  nx_d   = rsp.link;
                end
              end
              if (full) begin
                fin    = 1'b1;
                fin_st = ST_FULL;
              end else begin
                state_d = S_ALLOC;
              end
            end else if (!live(rsp.link)) begin
              fin    = 1'b1;
              fin_st = ST_NOT_FOUND;
            end else begin
              prev_d      = cur_q;
              cur_d       = rsp.link;
              req.rd_en   = 1'b1;
              req.rd_addr = rsp.link;
            end
          end
          ACT_DEL_AFTER: begin
            if (hit) begin
              if (!live(rsp.link)) begin
                fin    = 1'b1;
                fin_st = ST_NOT_FOUND;
              end else begin
                prev_d      = cur_q;
                nx_d        = rsp.link;
                req.rd_en   = 1'b1;
                req.rd_addr = rsp.link;
                state_d     = S_DELRD;
              end
            end else if (!live(rsp.link)) begin
              fin    = 1'b1;
              fin_st = ST_NOT_FOUND;
            end else begin
              cur_d       = rsp.link;
              req.rd_en   = 1'b1;
              req.rd_addr = rsp.link;
            end
          end
          ACT_DEL_HEAD, ACT_DEL_TAIL: begin
            if (act_q == ACT_DEL_HEAD || !live(rsp.link)) begin
              head_d = rsp.link;
              if (!live(rsp.link)) begin
                tail_d = NIL;
              end
              req.lnk_we   = 1'b1;
              req.lnk_addr = cur_q;
              req.lnk_data = free_q;
              free_d       = cur_q;
              cnt_d        = cnt_q - LEN_W'(1);
              fin          = 1'b1;
            end else if (rsp.link == tail_q) begin
              req.lnk_we   = 1'b1;
              req.lnk_addr = tail_q;
              req.lnk_data = free_q;
              free_d       = tail_q;
              cnt_d        = cnt_q - LEN_W'(1);
              w2a_d        = cur_q;
              w2d_d        = NIL;
              tail_d       = cur_q;
              state_d      = S_LINK2;
            end else begin
              cur_d       = rsp.link;
              req.rd_en   = 1'b1;
              req.rd_addr = rsp.link;
            end
          end
          ACT_DUMP: begin
            rv_d             = 1'b1;
            res_d.status     = ST_OK;
            res_d.item_value = rsp.val;
            res_d.length     = cnt_q;
            res_d.last       = !live(rsp.link);
            if (live(rsp.link)) begin
              cur_d       = rsp.link;
              req.rd_en   = 1'b1;
              req.rd_addr = rsp.link;
            end else begin
              state_d = S_IDLE;
            end
          end
          default: begin
            fin    = 1'b1;
            fin_st = ST_BAD;
          end
        endcase
      end

      S_ALLOC: begin
        if (live(free_q)) begin
          req.rd_en   = 1'b1;
          req.rd_addr = free_q;
          n_d         = free_q;
          state_d     = S_FREE;
        end else begin
          n_d     = PTR_W'(nu_q);
          nu_d    = nu_q + LEN_W'(1);
          state_d = S_PLACE;
        end
      end

      S_FREE: begin
        free_d  = rsp.link;
        state_d = S_PLACE;
      end

      S_PLACE: begin
        req.val_we   = 1'b1;
        req.val_addr = n_q;
        req.val_data = value_q;
        req.lnk_we   = 1'b1;
        req.lnk_addr = n_q;
        cnt_d        = cnt_q + LEN_W'(1);
        case (mode_q)
          M_HEAD: begin
            req.lnk_data = head_q;
            if (!live(head_q)) begin
              tail_d = n_q;
            end
            head_d = n_q;
            fin    = 1'b1;
          end
          M_TAIL: begin
            req.lnk_data = NIL;
            tail_d       = n_q;
            if (live(tail_q) && live(head_q)) begin
              w2a_d   = tail_q;
              w2d_d   = n_q;
              state_d = S_LINK2;
            end else begin
              head_d = n_q;
              fin    = 1'b1;
            end
          end
          default: begin
            req.lnk_data = nx_q;
            w2a_d        = prev_q;
            w2d_d        = n_q;
            if (prev_q == tail_q) begin
              tail_d = n_q;
            end
            state_d = S_LINK2;
          end
        endcase
      end

      S_DELRD: begin
        req.lnk_we   = 1'b1;
        req.lnk_addr = prev_q;
        req.lnk_data = rsp.link;
        if (nx_q == tail_q) begin
          tail_d = prev_q;
        end
        w2a_d   = nx_q;
        w2d_d   = free_q;
        free_d  = nx_q;
        cnt_d   = cnt_q - LEN_W'(1);
        state_d = S_LINK2;
      end

      S_LINK2: begin
        req.lnk_we   = 1'b1;
        req.lnk_addr = w2a_q;
        req.lnk_data = w2d_q;
        fin          = 1'b1;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d          = S_IDLE;
      rv_d             = 1'b1;
      res_d.status     = fin_st;
      res_d.item_value = '0;
      res_d.length     = cnt_d;
      res_d.last       = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= NIL;
      tail_q  <= NIL;
      free_q  <= NIL;
      nu_q    <= '0;
      cnt_q   <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      nu_q    <= nu_d;
      cnt_q   <= cnt_d;
      rv_q    <= rv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    value_q <= value_d;
    key_q   <= key_d;
    cur_q   <= cur_d;
    prev_q  <= prev_d;
    nx_q    <= nx_d;
    n_q     <= n_d;
    w2a_q   <= w2a_d;
    w2d_q   <= w2d_d;
    mode_q  <= mode_d;
    res_q   <= res_d;
  end

  assign busy_o      = state_q != S_IDLE;
  assign res_valid_o = rv_q;
  assign res_o       = res_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ksll_checker.sv =====
// port-level checks for the keyed singly linked list and their binding
`default_nettype none
`include "keyed_singly_linked_list_defines.svh"
module ksll_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start_i,
  input wire ksll_pkg::item_t   item_i,
  input wire logic              busy_o,
  input wire logic              res_valid_o,
  input wire ksll_pkg::result_t res_o
);
  import ksll_pkg::*;

  `KSLL_ASSERT_NEXT(dump_streams, res_valid_o && !res_o.last, res_valid_o)
  `KSLL_ASSERT_NEXT(item_answered, start_i && !busy_o, busy_o || res_valid_o)
  `KSLL_ASSERT_IMPLY(error_is_last, res_valid_o && res_o.status != ST_OK, res_o.last)
  `KSLL_ASSERT_IMPLY(error_no_value, res_valid_o && res_o.status != ST_OK,
                     res_o.item_value == '0)
  `KSLL_ASSERT_IMPLY(length_bound, res_valid_o, res_o.length <= LEN_W'(CAPACITY))
endmodule

bind keyed_singly_linked_list ksll_checker #(.CAPACITY(CAPACITY)) u_ksll_checker (.*);
`default_nettype wire

// ===== tb/keyed_singly_linked_list_test.sv =====
// testbench for the keyed singly linked list: directed and random actions checked against a model
`timescale 1ns / 100ps
`default_nettype none
module keyed_singly_linked_list_test;
  import ksll_pkg::*;

  localparam int CAP = 64;

  class list_scoreboard;
    logic signed [31:0] vals[$];
    result_t pending[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void push_res(logic [2:0] st, logic signed [31:0] v, logic last);
      result_t r;
      r.status = st;
      r.item_value = v;
      r.length = LEN_W'(vals.size());
      r.last = last;
      pending.push_back(r);
    endfunction

    function int find_key(logic signed [31:0] key);
      foreach (vals[i]) if (vals[i] == key) return i;
      return -1;
    endfunction

    function void note_item(item_t it);
      int p;
      logic [2:0] st;
      st = ST_OK;
      case (it.action)
        ACT_INS_HEAD:
          if (vals.size() >= CAP) st = ST_FULL;
          else vals.push_front(it.value);
        ACT_INS_TAIL:
          if (vals.size() >= CAP) st = ST_FULL;
          else vals.push_back(it.value);
        ACT_INS_BEFORE, ACT_INS_AFTER: begin
          p = find_key(it.key);
          if (vals.size() == 0) st = ST_EMPTY;
          else if (p < 0) st = ST_NOT_FOUND;
          else if (vals.size() >= CAP) st = ST_FULL;
          else if (it.action == ACT_INS_BEFORE) vals.insert(p, it.value);
          else vals.insert(p + 1, it.value);
        end
        ACT_DEL_HEAD:
          if (vals.size() == 0) st = ST_EMPTY;
          else void'(vals.pop_front());
        ACT_DEL_TAIL:
          if (vals.size() == 0) st = ST_EMPTY;
          else void'(vals.pop_back());
        ACT_DEL_AFTER: begin
          p = find_key(it.key);
          if (vals.size() == 0) st = ST_EMPTY;
          else if (p < 0 || p == vals.size() - 1) st = ST_NOT_FOUND;
          else vals.delete(p + 1);
        end
        ACT_CLEAR: vals.delete();
        ACT_DUMP: begin
          if (vals.size() == 0) st = ST_EMPTY;
          else begin
            foreach (vals[i]) push_res(ST_OK, vals[i], i == vals.size() - 1);
            return;
          end
        end
        default: st = ST_BAD;
      endcase
      push_res(st, 0, 1'b1);
    endfunction

    function void check_result(result_t got);
      result_t w;
      if (pending.size() == 0) begin
        $error("unexpected result status=%0d value=%0d", got.status, got.item_value);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (got.status !== w.status) begin
        $error("status: expected %0d, got %0d", w.status, got.status); errors++;
      end
      if (got.item_value !== w.item_value) begin
        $error("item_value: expected %0d, got %0d", w.item_value, got.item_value); errors++;
      end
      if (got.length !== w.length) begin
        $error("length: expected %0d, got %0d", w.length, got.length); errors++;
      end
      if (got.last !== w.last) begin
        $error("last: expected %0d, got %0d", w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk_i, rst_ni, start_i;
  item_t item_i;
  logic busy_o, res_valid_o;
  result_t res_o;
  list_scoreboard board;
  int unsigned cycles = 0;
  int burst_left;

  keyed_singly_linked_list #(.CAPACITY(CAP)) DUT (
    .clk_i, .rst_ni, .start_i, .item_i, .busy_o, .res_valid_o, .res_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_ni && res_valid_o) board.check_result(res_o);
  end

  function automatic logic signed [31:0] pick_value();
    // narrow values make key hits and duplicates common
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom;
      default: return $urandom_range(0, 11) - 6;
    endcase
  endfunction

  task automatic send_item(logic [3:0] act, logic signed [31:0] v, logic signed [31:0] k);
    int gap;
    item_t it;
    it = '{action: act, value: v, key: k};
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    start_i <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    board.note_item(it);
  endtask

  task automatic random_item(int fill_bias);
    logic [3:0] act;
    int r;
    logic signed [31:0] k;
    r = $urandom_range(0, 99);
    if (r < fill_bias) act = 4'($urandom_range(0, 3));
    else if (r < 90) act = 4'($urandom_range(4, 8));
    else if (r < 95) act = ACT_DUMP;
    else act = 4'($urandom_range(0, 15));
    if (board.vals.size() > 0 && $urandom_range(0, 3) != 0)
      k = board.vals[$urandom_range(0, board.vals.size() - 1)];
    else k = pick_value();
    if (act == ACT_CLEAR && $urandom_range(0, 3) != 0) act = ACT_DUMP;
    send_item(act, pick_value(), k);
  endtask

  initial begin
    board = new();
    burst_left = 0;
    start_i = 1'b0;
    item_i = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // empty list cases, then a short list with edge values and bad actions
    send_item(ACT_DUMP, 0, 0);
    send_item(ACT_DEL_HEAD, 0, 0);
    send_item(ACT_DEL_TAIL, 0, 0);
    send_item(ACT_DEL_AFTER, 0, 5);
    send_item(ACT_INS_BEFORE, 1, 5);
    send_item(ACT_INS_AFTER, 1, 5);
    send_item(ACT_INS_HEAD, 32'sh7fffffff, 0);
    send_item(ACT_INS_TAIL, 32'sh80000000, 0);
    send_item(ACT_INS_BEFORE, 3, 32'sh80000000);
    send_item(ACT_INS_AFTER, 4, 32'sh7fffffff);
    send_item(ACT_INS_BEFORE, 9, 77);
    send_item(ACT_DEL_AFTER, 0, 32'sh80000000);
    send_item(ACT_DEL_AFTER, 0, 32'sh7fffffff);
    send_item(ACT_DUMP, 0, 0);
    send_item(ACT_DEL_TAIL, 0, 0);
    send_item(ACT_DEL_HEAD, 0, 0);
    send_item(4'd9, 0, 0);
    send_item(4'd15, -1, -1);
    send_item(ACT_CLEAR, 0, 0);
    // fill the pool past capacity, then full head and keyed inserts
    for (int i = 0; i < CAP + 2; i++) send_item(ACT_INS_TAIL, i, 0);
    send_item(ACT_INS_HEAD, -1, 0);
    send_item(ACT_INS_AFTER, -1, 3);
    send_item(ACT_INS_BEFORE, -1, 63);
    send_item(ACT_DEL_TAIL, 0, 0);
    send_item(ACT_DUMP, 0, 0);
    send_item(ACT_CLEAR, 0, 0);
    for (int i = 0; i < 340; i++) random_item(i % 100 < 60 ? 70 : 35);
    send_item(ACT_DUMP, 0, 0);
    start_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire
